### sv/periodic_timer_bank_defines.svh
// Assertion helpers shared by the timer bank modules.
`ifndef PERIODIC_TIMER_BANK_DEFINES_SVH
`define PERIODIC_TIMER_BANK_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PTB_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define PTB_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### sv/ptb_pkg.sv
package ptb_pkg;

  localparam int SLOTS_DEF = 16;

  localparam int TICK_W   = 10;
  localparam int MINP_W   = 16;
  localparam int PERIOD_W = 23;
  localparam int HANDLER_W = 8;
  localparam int SLOTIDX_W = 4;
  localparam int ELAPSED_W = 24;
  localparam int KIND_W   = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int REC_W    = ELAPSED_W + PERIOD_W + HANDLER_W;

  localparam logic [TICK_W-1:0] TICK_RST = 10'd50;
  localparam logic [MINP_W-1:0] MINP_RST = 16'd100;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PER  = 2'd1;

  // opcodes
  localparam logic [1:0] OP_REQUEST = 2'd0;
  localparam logic [1:0] OP_TICK    = 2'd1;
  localparam logic [1:0] OP_CANCEL  = 2'd2;

  // result kinds
  localparam logic [KIND_W-1:0] K_ACCEPTED  = 3'd0;
  localparam logic [KIND_W-1:0] K_TOO_SHORT = 3'd1;
  localparam logic [KIND_W-1:0] K_FULL      = 3'd2;
  localparam logic [KIND_W-1:0] K_FIRED     = 3'd3;
  localparam logic [KIND_W-1:0] K_TICK_DONE = 3'd4;
  localparam logic [KIND_W-1:0] K_CANCELLED = 3'd5;
  localparam logic [KIND_W-1:0] K_EMPTY     = 3'd6;

  typedef struct packed {
    logic              capture;   // latch item, clear scan index
    logic              idx_inc;
    logic              wr_req;    // write new timer at scan index, mark active
    logic              wr_tick;   // write back updated elapsed count
    logic              clr_active; // free the slot named by the cancel item
    logic              load_out;
    logic [KIND_W-1:0] out_kind;
  } ptb_cmd_t;

  typedef struct packed {
    logic [1:0] item_op;
    logic       too_short;
    logic       can_hit;
    logic       cur_active;
    logic       idx_last;
    logic       fires;
    logic       out_free;
  } ptb_stat_t;

endpackage

### sv/ptb_ram.sv
module ptb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [AW-1:0]        raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/ptb_datapath.sv
`include "periodic_timer_bank_defines.svh"

module ptb_datapath #(
  parameter int SLOTS = ptb_pkg::SLOTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ptb_pkg::ptb_cmd_t                  cmd,
  output ptb_pkg::ptb_stat_t                 stat,
  input  logic [1:0]                         in_opcode,
  input  logic [ptb_pkg::PERIOD_W-1:0]       in_period_ms,
  input  logic [ptb_pkg::HANDLER_W-1:0]      in_handler_id,
  input  logic [ptb_pkg::SLOTIDX_W-1:0]      in_slot_index,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ptb_pkg::KIND_W-1:0]         out_kind,
  output logic [ptb_pkg::SLOTIDX_W-1:0]      out_slot_number,
  output logic [ptb_pkg::HANDLER_W-1:0]      out_handler_out,
  output logic [ptb_pkg::PERIOD_W-1:0]       out_period_out,
  output logic                               out_last,
  input  logic                               cfg_we,
  input  logic [ptb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ptb_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int EW = ptb_pkg::ELAPSED_W;
  localparam int PW = ptb_pkg::PERIOD_W;
  localparam int HW = ptb_pkg::HANDLER_W;

  logic [ptb_pkg::TICK_W-1:0]    tick_len_r;
  logic [ptb_pkg::MINP_W-1:0]    min_per_r;
  logic [1:0]                    op_r;
  logic [PW-1:0]                 period_r;
  logic [HW-1:0]                 handler_r;
  logic [ptb_pkg::SLOTIDX_W-1:0] slot_r;
  logic [IW-1:0]                 idx_r;
  logic [SLOTS-1:0]              active_r;
  logic                          out_valid_r;
  logic [ptb_pkg::KIND_W-1:0]    kind_r;
  logic [ptb_pkg::SLOTIDX_W-1:0] oslot_r;
  logic [HW-1:0]                 ohandler_r;
  logic [PW-1:0]                 operiod_r;

  logic [IW-1:0]                 can_idx;
  logic [IW-1:0]                 raddr;
  logic                          ram_we;
  logic [ptb_pkg::REC_W-1:0]     wdata;
  logic [ptb_pkg::REC_W-1:0]     rdata;
  logic [EW-1:0]                 rd_elapsed;
  logic [PW-1:0]                 rd_period;
  logic [HW-1:0]                 rd_handler;
  logic [EW:0]                   sum;
  logic [EW-1:0]                 e_sat;
  logic [EW-1:0]                 e_new;
  logic                          fires;

  assign can_idx = IW'(slot_r);
  assign raddr   = (op_r == ptb_pkg::OP_CANCEL) ? can_idx : idx_r;

  assign {rd_elapsed, rd_period, rd_handler} = rdata;

  // elapsed + tick, clipped to the counter range before the period test
  assign sum   = {1'b0, rd_elapsed} + (EW + 1)'(tick_len_r);
  assign e_sat = sum[EW] ? ptb_pkg::ELAPSED_MAX : sum[EW-1:0];
  assign fires = e_sat >= {1'b0, rd_period};
  assign e_new = fires ? (e_sat - {1'b0, rd_period}) : e_sat;

  assign ram_we = cmd.wr_req | cmd.wr_tick;
  assign wdata  = cmd.wr_req ? {{EW{1'b0}}, period_r, handler_r}
                             : {e_new, rd_period, rd_handler};

  ptb_ram #(
    .WIDTH (ptb_pkg::REC_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    stat.item_op    = op_r;
    stat.too_short  = period_r < PW'(min_per_r);
    stat.can_hit    = (int'(slot_r) < SLOTS) && active_r[can_idx];
    stat.cur_active = active_r[idx_r];
    stat.idx_last   = idx_r == IW'(SLOTS - 1);
    stat.fires      = fires;
    stat.out_free   = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_len_r <= ptb_pkg::TICK_RST;
      min_per_r  <= ptb_pkg::MINP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ptb_pkg::CFG_TICK_LEN: tick_len_r <= cfg_wdata[ptb_pkg::TICK_W-1:0];
        ptb_pkg::CFG_MIN_PER:  min_per_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      active_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.capture) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.wr_req) begin
        active_r[idx_r] <= 1'b1;
      end
      if (cmd.clr_active) begin
        active_r[can_idx] <= 1'b0;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r      <= in_opcode;
      period_r  <= in_period_ms;
      handler_r <= in_handler_id;
      slot_r    <= in_slot_index;
    end
    if (cmd.load_out) begin
      kind_r <= cmd.out_kind;
      case (cmd.out_kind)
        ptb_pkg::K_ACCEPTED: begin
          oslot_r    <= ptb_pkg::SLOTIDX_W'(idx_r);
          ohandler_r <= handler_r;
          operiod_r  <= period_r;
        end
        ptb_pkg::K_FIRED: begin
          oslot_r    <= ptb_pkg::SLOTIDX_W'(idx_r);
          ohandler_r <= rd_handler;
          operiod_r  <= rd_period;
        end
        ptb_pkg::K_CANCELLED: begin
          oslot_r    <= slot_r;
          ohandler_r <= rd_handler;
          operiod_r  <= rd_period;
        end
        default: begin
          oslot_r    <= '0;
          ohandler_r <= '0;
          operiod_r  <= '0;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = kind_r;
  assign out_slot_number = oslot_r;
  assign out_handler_out = ohandler_r;
  assign out_period_out  = operiod_r;
  assign out_last        = kind_r != ptb_pkg::K_FIRED;

  // a new timer never lands on a slot in use
  `PTB_ASSERT_IMP(a_req_free_slot, cmd.wr_req, !active_r[idx_r])

endmodule

### sv/ptb_ctrl.sv
`include "periodic_timer_bank_defines.svh"

module ptb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ptb_pkg::ptb_stat_t stat,
  output ptb_pkg::ptb_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DISP    = 4'd1;
  localparam logic [3:0] S_REQ     = 4'd2;
  localparam logic [3:0] S_SHORT   = 4'd3;
  localparam logic [3:0] S_FULL    = 4'd4;
  localparam logic [3:0] S_TICK_RD = 4'd5;
  localparam logic [3:0] S_TICK_EV = 4'd6;
  localparam logic [3:0] S_TDONE   = 4'd7;
  localparam logic [3:0] S_CAN_EV  = 4'd8;
  localparam logic [3:0] S_EMPTY   = 4'd9;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r) inside
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DISP;
        end
      end
      S_DISP: begin
        // cancel read is issued here, data is ready in S_CAN_EV
        unique case (stat.item_op)
          ptb_pkg::OP_REQUEST: state_nxt = stat.too_short ? S_SHORT : S_REQ;
          ptb_pkg::OP_TICK:    state_nxt = S_TICK_RD;
          ptb_pkg::OP_CANCEL:  state_nxt = stat.can_hit ? S_CAN_EV : S_EMPTY;
          default:             state_nxt = S_IDLE;
        endcase
      end
      S_REQ: begin
        if (!stat.cur_active) begin
          if (stat.out_free) begin
            cmd.wr_req   = 1'b1;
            cmd.load_out = 1'b1;
            cmd.out_kind = ptb_pkg::K_ACCEPTED;
            state_nxt    = S_IDLE;
          end
        end else if (stat.idx_last) begin
          state_nxt = S_FULL;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_SHORT, S_FULL, S_TDONE, S_EMPTY: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_kind = (state_r == S_SHORT) ? ptb_pkg::K_TOO_SHORT :
                         (state_r == S_FULL)  ? ptb_pkg::K_FULL :
                         (state_r == S_TDONE) ? ptb_pkg::K_TICK_DONE : ptb_pkg::K_EMPTY;
          state_nxt    = S_IDLE;
        end
      end
      S_TICK_RD: begin
        if (stat.cur_active) begin
          state_nxt = S_TICK_EV;
        end else if (stat.idx_last) begin
          state_nxt = S_TDONE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_TICK_EV: begin
        // a firing slot holds until the result register frees up
        if (!stat.fires || stat.out_free) begin
          cmd.wr_tick  = 1'b1;
          cmd.load_out = stat.fires;
          cmd.out_kind = ptb_pkg::K_FIRED;
          if (stat.idx_last) begin
            state_nxt = S_TDONE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_TICK_RD;
          end
        end
      end
      S_CAN_EV: begin
        if (stat.out_free) begin
          cmd.clr_active = 1'b1;
          cmd.load_out   = 1'b1;
          cmd.out_kind   = ptb_pkg::K_CANCELLED;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = state_r == S_IDLE;

  `PTB_ASSERT_NXT(a_one_item, in_valid && in_ready, !in_ready)
  `PTB_ASSERT_IMP(a_out_room, cmd.load_out, stat.out_free)
  `PTB_ASSERT_IMP(a_one_write, cmd.wr_req, !cmd.wr_tick && !cmd.clr_active)

endmodule

### sv/periodic_timer_bank.sv
// channel   | handshake             | payload
// ----------+-----------------------+---------------------------------------------
// in        | in_valid / in_ready   | opcode, period_ms, handler_id, slot_index
// out       | out_valid / out_ready | kind, slot_number, handler_out, period_out, last
// cfg       | cfg_we (no wait)      | cfg_index, cfg_wdata
//
// One item at a time. Request: linear free-slot scan from slot 0.
// Tick: scans every slot and writes back an updated slot record for each active slot.
// Cancel: one slot-record RAM read; ignored opcode: no result. A full result register stalls the item.
// Reset (synchronous, rst_n low) clears all slots; timer RAM needs no clearing.
module periodic_timer_bank #(
  parameter int SLOTS = ptb_pkg::SLOTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         in_opcode,
  input  logic [ptb_pkg::PERIOD_W-1:0]       in_period_ms,
  input  logic [ptb_pkg::HANDLER_W-1:0]      in_handler_id,
  input  logic [ptb_pkg::SLOTIDX_W-1:0]      in_slot_index,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ptb_pkg::KIND_W-1:0]         out_kind,
  output logic [ptb_pkg::SLOTIDX_W-1:0]      out_slot_number,
  output logic [ptb_pkg::HANDLER_W-1:0]      out_handler_out,
  output logic [ptb_pkg::PERIOD_W-1:0]       out_period_out,
  output logic                               out_last,
  input  logic                               cfg_we,
  input  logic [ptb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ptb_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  ptb_pkg::ptb_cmd_t  cmd;
  ptb_pkg::ptb_stat_t stat;

  ptb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ptb_datapath #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_opcode       (in_opcode),
    .in_period_ms    (in_period_ms),
    .in_handler_id   (in_handler_id),
    .in_slot_index   (in_slot_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_slot_number (out_slot_number),
    .out_handler_out (out_handler_out),
    .out_period_out  (out_period_out),
    .out_last        (out_last),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

endmodule

### bench/tb_periodic_timer_bank.sv
module tb_periodic_timer_bank;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = ptb_pkg::SLOTS_DEF;
  localparam int DRAIN = 4 * NSLOT + 16;
  localparam int LIMIT = 600000;
  localparam int HOLD_CYCLES = 300;
  localparam int PW = ptb_pkg::PERIOD_W;
  localparam int HW = ptb_pkg::HANDLER_W;
  localparam int SW = ptb_pkg::SLOTIDX_W;
  localparam int KW = ptb_pkg::KIND_W;
  localparam int EW = ptb_pkg::ELAPSED_W;
  localparam int TW = ptb_pkg::TICK_W;
  localparam int MW = ptb_pkg::MINP_W;
  localparam int IXW = ptb_pkg::CFG_IDX_W;
  localparam int DW = ptb_pkg::CFG_DATA_W;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [IXW-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic [KW-1:0] kind;
    logic [SW-1:0] slot;
    logic [HW-1:0] handler;
    logic [PW-1:0] period;
    logic          last;
  } timer_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_opcode = ptb_pkg::OP_REQUEST;
  logic [PW-1:0] in_period_ms = '0;
  logic [HW-1:0] in_handler_id = '0;
  logic [SW-1:0] in_slot_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [KW-1:0] out_kind;
  logic [SW-1:0] out_slot_number;
  logic [HW-1:0] out_handler_out;
  logic [PW-1:0] out_period_out;
  logic out_last;
  logic cfg_we = 1'b0;
  logic [IXW-1:0] cfg_index = '0;
  logic [DW-1:0] cfg_wdata = '0;

  // timer bank shadow state
  logic [TW-1:0] tick_len;
  logic [MW-1:0] min_period;
  bit            slot_on [NSLOT];
  logic [EW-1:0] slot_elapsed [NSLOT];
  logic [PW-1:0] slot_period [NSLOT];
  logic [HW-1:0] slot_handler [NSLOT];

  timer_result_t awaited_results[$];
  int err_cnt = 0;
  int cycle_cnt = 0;
  bit steady = 1'b0;
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;

  periodic_timer_bank #(.SLOTS(NSLOT)) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_period_ms    (in_period_ms),
    .in_handler_id   (in_handler_id),
    .in_slot_index   (in_slot_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_slot_number (out_slot_number),
    .out_handler_out (out_handler_out),
    .out_period_out  (out_period_out),
    .out_last        (out_last),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    while (cycle_cnt < LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycle_cnt);
    err_cnt++;
  endtask

  function automatic logic [PW-1:0] rnd_period();
    return PW'($urandom());
  endfunction

  function automatic logic [HW-1:0] rnd_handler();
    return HW'($urandom());
  endfunction

  function automatic logic [SW-1:0] rnd_slot();
    return SW'($urandom());
  endfunction

  function automatic void queue_result(logic [KW-1:0] k, logic [SW-1:0] s,
                                       logic [HW-1:0] h, logic [PW-1:0] p,
                                       logic l);
    timer_result_t r;
    r.kind = k;
    r.slot = s;
    r.handler = h;
    r.period = p;
    r.last = l;
    awaited_results = {awaited_results, r};
  endfunction

  function automatic void reset_timer_state();
    tick_len = ptb_pkg::TICK_RST;
    min_period = ptb_pkg::MINP_RST;
    for (int i = 0; i < NSLOT; i++) begin
      slot_on[i] = 1'b0;
      slot_elapsed[i] = '0;
      slot_period[i] = '0;
      slot_handler[i] = '0;
    end
  endfunction

  // Applies one accepted item to the shadow bank and queues what it should produce.
  function automatic void apply_to_timer_state(logic [1:0] op, logic [PW-1:0] per,
                                               logic [HW-1:0] hid,
                                               logic [SW-1:0] sidx);
    logic [EW:0] sum;
    bit placed;
    placed = 1'b0;
    case (op)
      ptb_pkg::OP_REQUEST: begin
        if (per < PW'(min_period)) begin
          queue_result(ptb_pkg::K_TOO_SHORT, '0, '0, '0, 1'b1);
        end else begin
          for (int i = 0; i < NSLOT; i++) begin
            if (!placed && !slot_on[i]) begin
              placed = 1'b1;
              slot_on[i] = 1'b1;
              slot_elapsed[i] = '0;
              slot_period[i] = per;
              slot_handler[i] = hid;
              queue_result(ptb_pkg::K_ACCEPTED, SW'(i), hid, per, 1'b1);
            end
          end
          if (!placed) queue_result(ptb_pkg::K_FULL, '0, '0, '0, 1'b1);
        end
      end
      ptb_pkg::OP_TICK: begin
        for (int i = 0; i < NSLOT; i++) begin
          if (slot_on[i]) begin
            sum = {1'b0, slot_elapsed[i]} + (EW + 1)'(tick_len);
            if (sum > {1'b0, ptb_pkg::ELAPSED_MAX}) sum = {1'b0, ptb_pkg::ELAPSED_MAX};
            if (sum >= (EW + 1)'(slot_period[i])) begin
              sum = sum - (EW + 1)'(slot_period[i]);
              queue_result(ptb_pkg::K_FIRED, SW'(i), slot_handler[i], slot_period[i], 1'b0);
            end
            slot_elapsed[i] = sum[EW-1:0];
          end
        end
        queue_result(ptb_pkg::K_TICK_DONE, '0, '0, '0, 1'b1);
      end
      ptb_pkg::OP_CANCEL: begin
        if (int'(sidx) < NSLOT && slot_on[sidx]) begin
          slot_on[sidx] = 1'b0;
          queue_result(ptb_pkg::K_CANCELLED, sidx, slot_handler[sidx], slot_period[sidx],
                       1'b1);
        end else begin
          queue_result(ptb_pkg::K_EMPTY, '0, '0, '0, 1'b1);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [SW-1:0] pick_active_slot(logic [SW-1:0] fallback);
    int live[$];
    for (int i = 0; i < NSLOT; i++)
      if (slot_on[i]) live = {live, i};
    if (live.size() == 0) return fallback;
    return SW'(live[$urandom_range(0, live.size() - 1)]);
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(0, 99) >= 31);
    end
  end

  always @(posedge clk) begin
    timer_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("result with none awaited, kind", int'(out_kind), 0);
      end else begin
        want = awaited_results.pop_front();
        if (out_kind !== want.kind)
          report_mismatch("kind", int'(out_kind), int'(want.kind));
        if (out_slot_number !== want.slot)
          report_mismatch("slot_number", int'(out_slot_number), int'(want.slot));
        if (out_handler_out !== want.handler)
          report_mismatch("handler_out", int'(out_handler_out), int'(want.handler));
        if (out_period_out !== want.period)
          report_mismatch("period_out", int'(out_period_out), int'(want.period));
        if (out_last !== want.last)
          report_mismatch("last", int'(out_last), int'(want.last));
      end
    end
  end

  // valid stays high after acceptance; the next call or wait_quiet settles it
  task automatic issue_item(logic [1:0] op, logic [PW-1:0] per,
                            logic [HW-1:0] hid, logic [SW-1:0] sidx);
    int gap;
    gap = 0;
    if (!steady)
      while (gap < 20 && $urandom_range(0, 99) < 31) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_period_ms <= per;
    in_handler_id <= hid;
    in_slot_index <= sidx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_to_timer_state(op, per, hid, sidx);
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(logic [IXW-1:0] idx, logic [DW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == ptb_pkg::CFG_TICK_LEN) tick_len = val[TW-1:0];
    else if (idx == ptb_pkg::CFG_MIN_PER) min_period = val;
  endtask

  task automatic set_timing(int tick, int minp);
    wait_quiet();
    write_reg(ptb_pkg::CFG_TICK_LEN, DW'(tick));
    write_reg(ptb_pkg::CFG_MIN_PER, DW'(minp));
  endtask

  task automatic clear_all_slots();
    for (int i = 0; i < NSLOT; i++)
      if (slot_on[i]) issue_item(ptb_pkg::OP_CANCEL, rnd_period(), rnd_handler(), SW'(i));
  endtask

  // reset settings: refusals, field extremes, cancel cases, filling the bank
  task automatic test_directed();
    issue_item(ptb_pkg::OP_REQUEST, 23'd0, 8'hFF, 4'hF);
    issue_item(ptb_pkg::OP_REQUEST, 23'd99, 8'hA5, 4'h0);
    issue_item(ptb_pkg::OP_REQUEST, 23'd100, 8'h00, 4'hF);
    issue_item(ptb_pkg::OP_REQUEST, 23'h7FFFFF, 8'hFF, 4'h0);
    issue_item(ptb_pkg::OP_TICK, 23'h7FFFFF, 8'hFF, 4'hF);
    issue_item(ptb_pkg::OP_TICK, 23'd0, 8'h00, 4'h0);
    issue_item(ptb_pkg::OP_CANCEL, 23'd0, 8'h00, 4'd1);
    issue_item(ptb_pkg::OP_CANCEL, 23'd0, 8'h00, 4'd1);
    issue_item(ptb_pkg::OP_CANCEL, 23'h7FFFFF, 8'hFF, 4'hF);
    issue_item(OP_UNUSED, 23'h7FFFFF, 8'hFF, 4'hF);
    for (int k = 0; k < NSLOT - 1; k++)
      issue_item(ptb_pkg::OP_REQUEST, PW'(100 + 50 * k), rnd_handler(), rnd_slot());
    issue_item(ptb_pkg::OP_REQUEST, 23'd5000, 8'h3C, 4'h0);
    issue_item(ptb_pkg::OP_TICK, rnd_period(), rnd_handler(), rnd_slot());
    clear_all_slots();
  endtask

  // periods below the tick length, and the top of the minimum period range
  task automatic test_short_periods();
    set_timing(1000, 0);
    write_reg(CFG_SPARE, 16'hFFFF);
    issue_item(ptb_pkg::OP_REQUEST, 23'd0, 8'h11, rnd_slot());
    issue_item(ptb_pkg::OP_REQUEST, 23'd1, 8'h22, rnd_slot());
    issue_item(ptb_pkg::OP_REQUEST, 23'd999, 8'h33, rnd_slot());
    repeat (3) issue_item(ptb_pkg::OP_TICK, rnd_period(), rnd_handler(), rnd_slot());
    set_timing(1, 65535);
    issue_item(ptb_pkg::OP_REQUEST, 23'd65534, 8'h44, rnd_slot());
    issue_item(ptb_pkg::OP_REQUEST, 23'd65535, 8'h55, rnd_slot());
    repeat (2) issue_item(ptb_pkg::OP_TICK, rnd_period(), rnd_handler(), rnd_slot());
    clear_all_slots();
  endtask

  task automatic test_random_mix(int n_items, int tick, int minp, bit calm);
    int r;
    int pick;
    logic [1:0] op;
    logic [PW-1:0] per;
    logic [SW-1:0] sidx;
    set_timing(tick, minp);
    steady = calm;
    repeat (n_items) begin
      r = $urandom_range(0, 99);
      per = rnd_period();
      sidx = rnd_slot();
      if (r < 40) begin
        op = ptb_pkg::OP_REQUEST;
        pick = $urandom_range(0, 99);
        if (pick < 70) per = PW'(minp + $urandom_range(0, 3 * tick));
        else if (pick < 85 && minp > 0) per = PW'($urandom_range(0, minp - 1));
      end else if (r < 75) begin
        op = ptb_pkg::OP_TICK;
      end else if (r < 95) begin
        op = ptb_pkg::OP_CANCEL;
        if ($urandom_range(0, 3) != 0) sidx = pick_active_slot(sidx);
      end else begin
        op = OP_UNUSED;
      end
      issue_item(op, per, rnd_handler(), sidx);
    end
    steady = 1'b0;
  endtask

  // full bank firing every tick while the receiver holds off
  task automatic test_output_stall();
    set_timing(1000, 1);
    clear_all_slots();
    steady = 1'b1;
    for (int k = 0; k < NSLOT; k++)
      issue_item(ptb_pkg::OP_REQUEST, PW'($urandom_range(1, 1000)), rnd_handler(),
                 rnd_slot());
    hold_token <= hold_token + 1;
    repeat (5) issue_item(ptb_pkg::OP_TICK, rnd_period(), rnd_handler(), rnd_slot());
    steady = 1'b0;
    clear_all_slots();
  endtask

  initial begin
    reset_timer_state();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_short_periods();
    test_random_mix(12, 1, 1, 1'b0);
    test_random_mix(10, 1000, 65535, 1'b0);
    test_random_mix(16, $urandom_range(1, 1000), $urandom_range(1, 2000), 1'b1);
    test_random_mix(12, 1000, 1, 1'b0);
    test_random_mix(10, int'(ptb_pkg::TICK_RST), int'(ptb_pkg::MINP_RST), 1'b0);
    test_output_stall();
    wait_quiet();
    if (err_cnt == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
